// File: rtl/bse_pkg.sv
// Shared widths, codes and vector types of the Bezier spline evaluator.
package bse_pkg;

	localparam int T_W        = 24;
	localparam int T_FRAC     = 16;
	localparam int COORD_W    = 32;
	localparam int HW         = 42;
	localparam int CW         = 38;
	localparam int IDX_W      = 6;
	localparam int SEL_W      = 2;
	localparam int PC_W       = 7;
	localparam int WRAP_W     = 2;
	localparam int SEG_OUT_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [SEL_W-1:0] SEL_POS   = 2'd0;
	localparam logic [SEL_W-1:0] SEL_IN    = 2'd1;
	localparam logic [SEL_W-1:0] SEL_OUT   = 2'd2;
	localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

	localparam logic [WRAP_W-1:0] WRAP_CLAMP  = 2'd0;
	localparam logic [WRAP_W-1:0] WRAP_REPEAT = 2'd1;
	localparam logic [WRAP_W-1:0] WRAP_EXTRAP = 2'd2;
	localparam logic [WRAP_W-1:0] WRAP_SPARE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 1'b1;

	localparam logic [PC_W-1:0] PC_RESET = 7'd2;

	localparam logic signed [T_W-1:0] T_ONE        = 24'sh010000;
	localparam logic signed [HW-1:0]  HORNER_LIMIT = 42'sh100_0000_0000;

	typedef logic [2:0][COORD_W-1:0] vec3_t;
	typedef logic [2:0][HW-1:0]      hvec_t;
	typedef logic [2:0][CW-1:0]      cvec_t;

endpackage

// File: rtl/bse_if.sv
// Handshake channels for command words and result words.
interface bse_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  operation;
	logic        [bse_pkg::IDX_W-1:0]      point_index;
	logic        [bse_pkg::SEL_W-1:0]      vector_select;
	logic signed [bse_pkg::COORD_W-1:0]    coord_x;
	logic signed [bse_pkg::COORD_W-1:0]    coord_y;
	logic signed [bse_pkg::COORD_W-1:0]    coord_z;
	logic signed [bse_pkg::T_W-1:0]        curve_param;

	modport source (output valid, operation, point_index, vector_select, coord_x, coord_y,
		coord_z, curve_param, input ready);
	modport sink (input valid, operation, point_index, vector_select, coord_x, coord_y,
		coord_z, curve_param, output ready);
endinterface

interface bse_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bse_pkg::COORD_W-1:0]    point_x;
	logic signed [bse_pkg::COORD_W-1:0]    point_y;
	logic signed [bse_pkg::COORD_W-1:0]    point_z;
	logic        [bse_pkg::SEG_OUT_W-1:0]  segment_used;

	modport source (output valid, point_x, point_y, point_z, segment_used, input ready);
	modport sink (input valid, point_x, point_y, point_z, segment_used, output ready);
endinterface

// File: rtl/bezier_spline_evaluator_top.sv
// Top level of the piecewise cubic Bezier spline evaluator.
// A command word passes the front register, the queue, the back pipeline and the result register.
// Throughput: one command word per cycle unless results stall; loads share the path, no result.
// A 4-entry queue joins the front stage to the back pipeline; while a finished point waits,
// the back pipeline holds and the front stage and queue take up to five more words.
// Reset clears control state, sets point_count to 2 and wrap_mode to clamp; stores stay undefined.
module bezier_spline_evaluator_top #(
	parameter int MAX_POINTS = 64,
	localparam int AW    = $clog2(MAX_POINTS),
	localparam int SW    = bse_pkg::T_W + AW + 1,
	localparam int ITEMW = 5 + 2 * AW + SW + 3 * bse_pkg::COORD_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bse_pkg::CFG_DATA_W-1:0]  cfg_data,
	bse_in_if.sink                          cmd,
	bse_out_if.source                       result
);

	logic [bse_pkg::PC_W-1:0]   point_count_q;
	logic [bse_pkg::WRAP_W-1:0] wrap_mode_q;
	logic                       push_valid;
	logic                       push_ready;
	logic [ITEMW-1:0]           push_item;
	logic                       pop_valid;
	logic                       pop;
	logic [ITEMW-1:0]           pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= bse_pkg::PC_RESET;
			wrap_mode_q   <= bse_pkg::WRAP_CLAMP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bse_pkg::REG_POINT_COUNT: point_count_q <= cfg_data[bse_pkg::PC_W-1:0];
				bse_pkg::REG_WRAP_MODE:   wrap_mode_q   <= cfg_data[bse_pkg::WRAP_W-1:0];
			endcase
		end
	end

	bse_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.point_count(point_count_q),
		.wrap_mode  (wrap_mode_q),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	bse_queue #(.WIDTH(ITEMW), .DEPTH(4)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data (push_item),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_data  (pop_item),
		.pop       (pop)
	);

	bse_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_item (pop_item),
		.pop      (pop),
		.result   (result)
	);

endmodule

// File: rtl/bse_queue.sv
// Small register FIFO between the classifying front end and the evaluation back end.
module bse_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data,
	input  logic             pop
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue fill count exceeds its depth");

	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue fill count did not follow a lone push");

endmodule

// File: rtl/bse_front.sv
// Front end: takes command words, scales the curve parameter and picks the segment.
module bse_front #(
	parameter int MAX_POINTS = 64,
	localparam int AW    = $clog2(MAX_POINTS),
	localparam int SW    = bse_pkg::T_W + AW + 1,
	localparam int ITEMW = 5 + 2 * AW + SW + 3 * bse_pkg::COORD_W,
	localparam int PCW   = (AW + 1 > bse_pkg::PC_W) ? AW + 1 : bse_pkg::PC_W,
	localparam int FLW   = SW - bse_pkg::T_FRAC
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bse_in_if.sink                      cmd,
	input  logic [bse_pkg::PC_W-1:0]    point_count,
	input  logic [bse_pkg::WRAP_W-1:0]  wrap_mode,
	output logic                        push_valid,
	output logic [ITEMW-1:0]            push_item,
	input  logic                        push_ready
);

	typedef struct packed {
		logic                  eval;
		logic                  special;
		logic                  load_ok;
		logic [1:0]            sel;
		logic [AW-1:0]         addr;
		logic [AW-1:0]         seg;
		logic signed [SW-1:0]  u;
		bse_pkg::vec3_t        coord;
	} item_t;

	logic [PCW-1:0]                  pc;
	logic [AW-1:0]                   n;
	logic signed [bse_pkg::T_W-1:0]  t;
	logic signed [bse_pkg::T_W-1:0]  t_eff;
	logic                            clamp_mode;
	logic                            low;
	logic                            high;
	logic signed [SW-1:0]            scaled_d;

	logic                            valid_s1;
	logic                            eval_s1;
	logic                            special_s1;
	logic                            high_s1;
	logic                            load_ok_s1;
	logic [1:0]                      sel_s1;
	logic [AW-1:0]                   idx_s1;
	bse_pkg::vec3_t                  coord_s1;
	logic signed [SW-1:0]            scaled_s1;
	logic [AW-1:0]                   n_s1;

	logic signed [FLW-1:0]           fl;
	logic [AW-1:0]                   seg;
	logic [AW-1:0]                   last_seg;
	item_t                           item;

	always_comb begin
		pc = PCW'(point_count);
		if (pc < PCW'(2)) begin
			pc = PCW'(2);
		end else if (pc > PCW'(MAX_POINTS)) begin
			pc = PCW'(MAX_POINTS);
		end
		n = AW'(pc - PCW'(1));
		t = cmd.curve_param;
		unique case (wrap_mode)
			bse_pkg::WRAP_REPEAT: begin
				t_eff      = bse_pkg::T_W'(t[bse_pkg::T_FRAC-1:0]);
				clamp_mode = 1'b0;
			end
			bse_pkg::WRAP_EXTRAP: begin
				t_eff      = t;
				clamp_mode = 1'b0;
			end
			bse_pkg::WRAP_CLAMP, bse_pkg::WRAP_SPARE: begin
				t_eff      = t;
				clamp_mode = 1'b1;
			end
		endcase
		low      = clamp_mode && (t <= 0);
		high     = clamp_mode && (t >= bse_pkg::T_ONE);
		scaled_d = SW'(t_eff) * $signed(SW'({1'b0, n}));
	end

	assign cmd.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			eval_s1    <= (cmd.operation == bse_pkg::OP_EVAL);
			special_s1 <= low || high;
			high_s1    <= high;
			load_ok_s1 <= (32'(cmd.point_index) < MAX_POINTS)
				&& (cmd.vector_select != bse_pkg::SEL_SPARE);
			sel_s1     <= cmd.vector_select;
			idx_s1     <= AW'(cmd.point_index);
			coord_s1   <= {cmd.coord_z, cmd.coord_y, cmd.coord_x};
			scaled_s1  <= scaled_d;
			n_s1       <= n;
		end
	end

	always_comb begin
		last_seg = n_s1 - AW'(1);
		fl       = FLW'(scaled_s1 >>> bse_pkg::T_FRAC);
		if (fl < 0) begin
			seg = '0;
		end else if (fl > $signed(FLW'(last_seg))) begin
			seg = last_seg;
		end else begin
			seg = AW'(fl);
		end
		item.eval    = eval_s1;
		item.special = special_s1;
		item.load_ok = load_ok_s1;
		item.sel     = sel_s1;
		item.u       = scaled_s1 - $signed(SW'({seg, {bse_pkg::T_FRAC{1'b0}}}));
		item.coord   = coord_s1;
		if (!eval_s1) begin
			item.addr = idx_s1;
			item.seg  = seg;
		end else if (special_s1) begin
			item.addr = high_s1 ? n_s1 : '0;
			item.seg  = high_s1 ? last_seg : '0;
		end else begin
			item.addr = seg;
			item.seg  = seg;
		end
	end

	assign push_item = item;

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && item.eval |-> item.seg < n_s1)
		else $error("segment index beyond the last segment");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid && $stable(scaled_s1))
		else $error("front word lost while the queue was full");

endmodule

// File: rtl/bse_horner_step.sv
// One Horner step for three coordinates: v*u split in two products, then shift, add, clamp.
module bse_horner_step #(
	parameter int SW     = 31,
	parameter int SIDE_W = 1,
	localparam int LOW_W = bse_pkg::T_FRAC + 1,
	localparam int PW    = bse_pkg::HW + SW,
	localparam int SUMW  = PW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  bse_pkg::hvec_t       v,
	input  logic signed [SW-1:0] u,
	input  bse_pkg::cvec_t       c,
	input  logic [SIDE_W-1:0]    side,
	output logic                 out_valid,
	output bse_pkg::hvec_t       v_out,
	output logic signed [SW-1:0] u_out,
	output logic [SIDE_W-1:0]    side_out
);

	localparam logic signed [SUMW-1:0] LIM = SUMW'(bse_pkg::HORNER_LIMIT);

	logic                                         valid_s1;
	logic signed [bse_pkg::HW+LOW_W:0]            lo_s1 [3];
	logic signed [bse_pkg::HW+SW-LOW_W-1:0]       hi_s1 [3];
	bse_pkg::cvec_t                               c_s1;
	logic signed [SW-1:0]                         u_s1;
	logic [SIDE_W-1:0]                            side_s1;

	logic signed [PW-1:0]                         prod [3];
	logic signed [SUMW-1:0]                       sum [3];
	bse_pkg::hvec_t                               v_d;

	logic                                         valid_s2;
	bse_pkg::hvec_t                               v_s2;
	logic signed [SW-1:0]                         u_s2;
	logic [SIDE_W-1:0]                            side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				lo_s1[i] <= $signed(v[i]) * $signed({1'b0, u[LOW_W-1:0]});
				hi_s1[i] <= $signed(v[i]) * $signed(u[SW-1:LOW_W]);
			end
			c_s1    <= c;
			u_s1    <= u;
			side_s1 <= side;
			v_s2    <= v_d;
			u_s2    <= u_s1;
			side_s2 <= side_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = PW'(lo_s1[i]) + (PW'(hi_s1[i]) <<< LOW_W);
			sum[i]  = SUMW'(prod[i] >>> bse_pkg::T_FRAC) + SUMW'($signed(c_s1[i]));
			if (sum[i] > LIM) begin
				v_d[i] = bse_pkg::HORNER_LIMIT;
			end else if (sum[i] < -LIM) begin
				v_d[i] = -bse_pkg::HORNER_LIMIT;
			end else begin
				v_d[i] = bse_pkg::HW'(sum[i]);
			end
		end
	end

	assign out_valid = valid_s2;
	assign v_out     = v_s2;
	assign u_out     = u_s2;
	assign side_out  = side_s2;

endmodule

// File: rtl/bse_back.sv
// Back end: control point stores, power-form coefficients, Horner pipeline and result register.
module bse_back #(
	parameter int MAX_POINTS = 64,
	localparam int AW    = $clog2(MAX_POINTS),
	localparam int SW    = bse_pkg::T_W + AW + 1,
	localparam int ITEMW = 5 + 2 * AW + SW + 3 * bse_pkg::COORD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  logic [ITEMW-1:0] pop_item,
	output logic             pop,
	bse_out_if.source        result
);

	typedef struct packed {
		logic                  eval;
		logic                  special;
		logic                  load_ok;
		logic [1:0]            sel;
		logic [AW-1:0]         addr;
		logic [AW-1:0]         seg;
		logic signed [SW-1:0]  u;
		bse_pkg::vec3_t        coord;
	} item_t;

	typedef struct packed {
		bse_pkg::cvec_t c1;
		bse_pkg::cvec_t c0;
		logic [AW-1:0]  seg;
	} side1_t;

	typedef struct packed {
		bse_pkg::cvec_t c0;
		logic [AW-1:0]  seg;
	} side2_t;

	localparam logic signed [bse_pkg::HW-1:0] SAT_MAX = bse_pkg::HW'(32'sh7FFF_FFFF);
	localparam logic signed [bse_pkg::HW-1:0] SAT_MIN = bse_pkg::HW'($signed(32'h8000_0000));

	function automatic logic [bse_pkg::COORD_W-1:0] sat32(input logic signed [bse_pkg::HW-1:0] v);
		if (v > SAT_MAX) begin
			return SAT_MAX[bse_pkg::COORD_W-1:0];
		end else if (v < SAT_MIN) begin
			return SAT_MIN[bse_pkg::COORD_W-1:0];
		end
		return v[bse_pkg::COORD_W-1:0];
	endfunction

	item_t                 item;
	logic                  adv;
	logic [AW-1:0]         seg_nx;

	bse_pkg::vec3_t        pos_mem [MAX_POINTS];
	bse_pkg::vec3_t        inh_mem [MAX_POINTS];
	bse_pkg::vec3_t        outh_mem [MAX_POINTS];

	logic                  valid_s1;
	logic                  special_s1;
	logic [AW-1:0]         seg_s1;
	logic signed [SW-1:0]  u_s1;
	bse_pkg::vec3_t        pa_s1;
	bse_pkg::vec3_t        pb_s1;
	bse_pkg::vec3_t        ho_s1;
	bse_pkg::vec3_t        hi_s1;

	bse_pkg::cvec_t        c0_d, c1_d, c2_d, c3_d;
	logic                  valid_s2;
	bse_pkg::cvec_t        c0_s2, c1_s2, c2_s2, c3_s2;
	logic signed [SW-1:0]  u_s2;
	logic [AW-1:0]         seg_s2;

	bse_pkg::hvec_t        v0;
	side1_t                side1_in, side1_out;
	side2_t                side2_in, side2_out;
	logic                  valid_h1, valid_h2, valid_h3;
	bse_pkg::hvec_t        v_h1, v_h2, v_h3;
	logic signed [SW-1:0]  u_h1, u_h2;
	logic [AW-1:0]         seg_h3;

	logic                  out_valid_q;
	bse_pkg::vec3_t        point_q;
	logic [bse_pkg::SEG_OUT_W-1:0] seg_q;

	assign item   = pop_item;
	assign adv    = !out_valid_q || result.ready;
	assign pop    = adv && pop_valid;
	assign seg_nx = item.seg + AW'(1);

	always_ff @(posedge clk) begin
		if (pop && !item.eval && item.load_ok) begin
			unique case (item.sel)
				bse_pkg::SEL_POS:   pos_mem[item.addr]  <= item.coord;
				bse_pkg::SEL_IN:    inh_mem[item.addr]  <= item.coord;
				bse_pkg::SEL_OUT:   outh_mem[item.addr] <= item.coord;
				bse_pkg::SEL_SPARE: ;
			endcase
		end
		if (adv) begin
			pa_s1      <= pos_mem[item.addr];
			pb_s1      <= pos_mem[seg_nx];
			ho_s1      <= outh_mem[item.seg];
			hi_s1      <= inh_mem[seg_nx];
			special_s1 <= item.special;
			seg_s1     <= item.seg;
			u_s1       <= item.u;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop && item.eval;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_h3;
		end
	end

	always_comb begin
		logic signed [bse_pkg::CW-1:0] p0, p1, p2, p3, d;
		for (int i = 0; i < 3; i++) begin
			p0 = bse_pkg::CW'($signed(pa_s1[i]));
			p1 = bse_pkg::CW'($signed(ho_s1[i]));
			p2 = bse_pkg::CW'($signed(hi_s1[i]));
			p3 = bse_pkg::CW'($signed(pb_s1[i]));
			c0_d[i] = p0;
			d       = p1 - p0;
			c1_d[i] = (d <<< 1) + d;
			d       = p0 - (p1 <<< 1) + p2;
			c2_d[i] = (d <<< 1) + d;
			c3_d[i] = p3 - ((p2 <<< 1) + p2) + ((p1 <<< 1) + p1) - p0;
			if (special_s1) begin
				c1_d[i] = '0;
				c2_d[i] = '0;
				c3_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_s2  <= c0_d;
			c1_s2  <= c1_d;
			c2_s2  <= c2_d;
			c3_s2  <= c3_d;
			u_s2   <= u_s1;
			seg_s2 <= seg_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v0[i] = bse_pkg::HW'($signed(c3_s2[i]));
		end
		side1_in.c1  = c1_s2;
		side1_in.c0  = c0_s2;
		side1_in.seg = seg_s2;
		side2_in.c0  = side1_out.c0;
		side2_in.seg = side1_out.seg;
	end

	bse_horner_step #(.SW(SW), .SIDE_W($bits(side1_t))) u_step1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (valid_s2),
		.v        (v0),
		.u        (u_s2),
		.c        (c2_s2),
		.side     (side1_in),
		.out_valid(valid_h1),
		.v_out    (v_h1),
		.u_out    (u_h1),
		.side_out (side1_out)
	);

	bse_horner_step #(.SW(SW), .SIDE_W($bits(side2_t))) u_step2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (valid_h1),
		.v        (v_h1),
		.u        (u_h1),
		.c        (side1_out.c1),
		.side     (side2_in),
		.out_valid(valid_h2),
		.v_out    (v_h2),
		.u_out    (u_h2),
		.side_out (side2_out)
	);

	bse_horner_step #(.SW(SW), .SIDE_W(AW)) u_step3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (valid_h2),
		.v        (v_h2),
		.u        (u_h2),
		.c        (side2_out.c0),
		.side     (side2_out.seg),
		.out_valid(valid_h3),
		.v_out    (v_h3),
		.u_out    (),
		.side_out (seg_h3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				point_q[i] <= sat32($signed(v_h3[i]));
			end
			seg_q <= bse_pkg::SEG_OUT_W'(seg_h3);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.point_x      = point_q[0];
	assign result.point_y      = point_q[1];
	assign result.point_z      = point_q[2];
	assign result.segment_used = seg_q;

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !item.eval |=> !valid_s1)
		else $error("a load word entered the evaluation pipeline");

endmodule
